>>> rtl/wseov_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wseov_pkg
// Shared types, codes and character classes for the extension offer checker.
// ============================================================================
package wseov_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE        = 2'd0,
        KIND_FIELD_END   = 2'd1,
        KIND_SECTION_END = 2'd2,
        KIND_UNUSED      = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        PH_ELEM   = 4'd0,
        PH_EXT    = 4'd1,
        PH_AFTER  = 4'd2,
        PH_PSTART = 4'd3,
        PH_PNAME  = 4'd4,
        PH_APNAME = 4'd5,
        PH_VSTART = 4'd6,
        PH_VTOKEN = 4'd7,
        PH_QUOTED = 4'd8,
        PH_QESC   = 4'd9
    } phase_t;

    typedef struct packed {
        phase_t parse_phase;
        logic   quoted_nonempty;
        logic   seen_field;
        logic   named_extension;
        logic   syntax_failed;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        parse_phase:     PH_ELEM,
        quoted_nonempty: 1'b0,
        seen_field:      1'b0,
        named_extension: 1'b0,
        syntax_failed:   1'b0
    };

    typedef struct packed {
        logic offers_valid;
        logic field_present;
    } result_t;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_EQUALS    = 8'h3D;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    function automatic logic is_tchar(input logic [7:0] c);
        logic alnum;
        logic special;
        alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h41 && c <= 8'h5A);
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: special = 1'b1;
            default: special = 1'b0;
        endcase
        return alnum || special;
    endfunction

    function automatic logic is_ows(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

>>> rtl/wseov_item_if.sv
`timescale 1ns / 1ps
// ============================================================================
// wseov_item_if
// Input channel: one header byte or a field or section boundary marker.
// ============================================================================
interface wseov_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value_byte;

    modport source (output valid, output kind, output value_byte, input ready);
    modport sink (input valid, input kind, input value_byte, output ready);
endinterface

>>> rtl/wseov_result_if.sv
`timescale 1ns / 1ps
// ============================================================================
// wseov_result_if
// Output channel: the verdict for one completed header section.
// ============================================================================
interface wseov_result_if;
    logic valid;
    logic ready;
    logic offers_valid;
    logic field_present;

    modport source (output valid, output offers_valid, output field_present, input ready);
    modport sink (input valid, input offers_valid, input field_present, output ready);
endinterface

>>> rtl/ws_extension_offer_validator.sv
`timescale 1ns / 1ps
// ============================================================================
// ws_extension_offer_validator
// Syntax check of Sec-WebSocket-Extensions field values over one header section.
// ============================================================================
// Path: a section-end transaction accepted into the input register loads the result
// register when it advances, and its verdict is then offered on the result channel.
// Throughput: one transaction per cycle; the grammar step is a single pass of
// logic between the input register and the parser state register. A section end
// waits in the input register only while an earlier verdict has not been taken.
// Reset: rst_n clears the valid flags and the parser state at once.
module ws_extension_offer_validator (
    input  logic                  clk,
    input  logic                  rst_n,
    wseov_item_if.sink            item,
    wseov_result_if.source        result
);

    logic                    stage_valid_reg;
    logic [1:0]              stage_kind_reg;
    logic [7:0]              stage_byte_reg;
    wseov_pkg::parse_state_t state_reg;
    wseov_pkg::parse_state_t state_next;
    logic                    out_valid_reg;
    wseov_pkg::result_t      out_reg;
    wseov_pkg::result_t      step_result;
    logic                    step_emit;
    logic                    advance;
    logic                    load_out;

    wseov_parser_step u_step (
        .state      (state_reg),
        .kind       (stage_kind_reg),
        .value_byte (stage_byte_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    assign advance  = stage_valid_reg && (!step_emit || !out_valid_reg || result.ready);
    assign load_out = advance && step_emit;

    assign item.ready           = !stage_valid_reg || advance;
    assign result.valid         = out_valid_reg;
    assign result.offers_valid  = out_reg.offers_valid;
    assign result.field_present = out_reg.field_present;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            state_reg       <= wseov_pkg::STATE_RESET;
            out_valid_reg   <= 1'b0;
        end else begin
            if (item.ready) begin
                stage_valid_reg <= item.valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready) begin
            stage_kind_reg <= item.kind;
            stage_byte_reg <= item.value_byte;
        end
        if (load_out) begin
            out_reg <= step_result;
        end
    end

    a_section_emits: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("Section end did not produce a result transaction.");

    a_section_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (state_reg.parse_phase == wseov_pkg::PH_ELEM) &&
                     !state_reg.seen_field && !state_reg.syntax_failed &&
                     !state_reg.named_extension)
        else $error("Parser state was not cleared after a section end.");

    a_failure_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.syntax_failed && !load_out) |=> state_reg.syntax_failed)
        else $error("Syntax failure cleared before the section ended.");

    a_absent_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !step_result.field_present && !state_reg.syntax_failed)
        |=> out_reg.offers_valid)
        else $error("Section without extension fields reported as invalid.");

endmodule

>>> rtl/wseov_parser_step.sv
`timescale 1ns / 1ps
// ============================================================================
// wseov_parser_step
// Next-state and result logic of the extension-list grammar for one item.
// ============================================================================
module wseov_parser_step (
    input  wseov_pkg::parse_state_t state,
    input  logic [1:0]              kind,
    input  logic [7:0]              value_byte,
    output wseov_pkg::parse_state_t state_next,
    output logic                    emit,
    output wseov_pkg::result_t      result
);

    function automatic wseov_pkg::parse_state_t after_byte(
        input wseov_pkg::parse_state_t s,
        input logic [7:0]              c,
        input logic                    eq_ok
    );
        wseov_pkg::parse_state_t r;
        r = s;
        if (wseov_pkg::is_ows(c)) begin
            r = s;
        end else if (c == wseov_pkg::CH_COMMA) begin
            r.parse_phase = wseov_pkg::PH_ELEM;
        end else if (c == wseov_pkg::CH_SEMICOLON) begin
            r.parse_phase = wseov_pkg::PH_PSTART;
        end else if (eq_ok && c == wseov_pkg::CH_EQUALS) begin
            r.parse_phase = wseov_pkg::PH_VSTART;
        end else begin
            r.syntax_failed = 1'b1;
        end
        return r;
    endfunction

    function automatic wseov_pkg::parse_state_t take_byte(
        input wseov_pkg::parse_state_t s,
        input logic [7:0]              c
    );
        wseov_pkg::parse_state_t r;
        logic                    tc;
        r  = s;
        tc = wseov_pkg::is_tchar(c);
        case (s.parse_phase)
            wseov_pkg::PH_ELEM:
            begin
                if (wseov_pkg::is_ows(c) || c == wseov_pkg::CH_COMMA) begin
                    r = s;
                end else if (tc) begin
                    r.named_extension = 1'b1;
                    r.parse_phase     = wseov_pkg::PH_EXT;
                end else begin
                    r.syntax_failed = 1'b1;
                end
            end
            wseov_pkg::PH_EXT, wseov_pkg::PH_VTOKEN:
            begin
                if (!tc) begin
                    r.parse_phase = wseov_pkg::PH_AFTER;
                    r = after_byte(r, c, 1'b0);
                end
            end
            wseov_pkg::PH_AFTER:
            begin
                r = after_byte(s, c, 1'b0);
            end
            wseov_pkg::PH_PSTART:
            begin
                if (tc) begin
                    r.parse_phase = wseov_pkg::PH_PNAME;
                end else if (!wseov_pkg::is_ows(c)) begin
                    r.syntax_failed = 1'b1;
                end
            end
            wseov_pkg::PH_PNAME:
            begin
                if (!tc) begin
                    r.parse_phase = wseov_pkg::PH_APNAME;
                    r = after_byte(r, c, 1'b1);
                end
            end
            wseov_pkg::PH_APNAME:
            begin
                r = after_byte(s, c, 1'b1);
            end
            wseov_pkg::PH_VSTART:
            begin
                if (c == wseov_pkg::CH_DQUOTE) begin
                    r.quoted_nonempty = 1'b0;
                    r.parse_phase     = wseov_pkg::PH_QUOTED;
                end else if (tc) begin
                    r.parse_phase = wseov_pkg::PH_VTOKEN;
                end else if (!wseov_pkg::is_ows(c)) begin
                    r.syntax_failed = 1'b1;
                end
            end
            wseov_pkg::PH_QUOTED:
            begin
                if (c == wseov_pkg::CH_DQUOTE) begin
                    if (s.quoted_nonempty) begin
                        r.parse_phase = wseov_pkg::PH_AFTER;
                    end else begin
                        r.syntax_failed = 1'b1;
                    end
                end else if (c == wseov_pkg::CH_BACKSLASH) begin
                    r.parse_phase = wseov_pkg::PH_QESC;
                end else if (tc) begin
                    r.quoted_nonempty = 1'b1;
                end else begin
                    r.syntax_failed = 1'b1;
                end
            end
            wseov_pkg::PH_QESC:
            begin
                if (tc) begin
                    r.quoted_nonempty = 1'b1;
                    r.parse_phase     = wseov_pkg::PH_QUOTED;
                end else begin
                    r.syntax_failed = 1'b1;
                end
            end
            default:
            begin
                r.syntax_failed = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic wseov_pkg::parse_state_t end_field(
        input wseov_pkg::parse_state_t s
    );
        wseov_pkg::parse_state_t r;
        r = s;
        if (!s.syntax_failed) begin
            case (s.parse_phase)
                wseov_pkg::PH_ELEM, wseov_pkg::PH_EXT, wseov_pkg::PH_AFTER,
                wseov_pkg::PH_PNAME, wseov_pkg::PH_APNAME, wseov_pkg::PH_VTOKEN:
                begin
                    r.syntax_failed = 1'b0;
                end
                default:
                begin
                    r.syntax_failed = 1'b1;
                end
            endcase
        end
        r.parse_phase     = wseov_pkg::PH_ELEM;
        r.quoted_nonempty = 1'b0;
        return r;
    endfunction

    wseov_pkg::parse_state_t closed;

    always_comb
    begin
        state_next           = state;
        emit                 = 1'b0;
        closed               = end_field(state);
        result.offers_valid  = !closed.syntax_failed &&
                               (!closed.seen_field || closed.named_extension);
        result.field_present = closed.seen_field;
        case (kind)
            wseov_pkg::KIND_BYTE:
            begin
                if (!state.syntax_failed) begin
                    state_next = take_byte(state, value_byte);
                end
                state_next.seen_field = 1'b1;
            end
            wseov_pkg::KIND_FIELD_END:
            begin
                state_next            = closed;
                state_next.seen_field = 1'b1;
            end
            wseov_pkg::KIND_SECTION_END:
            begin
                state_next = wseov_pkg::STATE_RESET;
                emit       = 1'b1;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule
